// ===== rtl/length_prefixed_message_ring_unit_defines.svh =====
// Assertion macros for the message ring unit.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_UNIT_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_UNIT_DEFINES_SVH

// Same-cycle implication.
`define LPMR_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define LPMR_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/lpmr_pkg.sv =====
package lpmr_pkg;

	localparam int RingBytes   = 1024;
	localparam int HeaderBytes = 4;
	localparam int PtrW        = $clog2(RingBytes);
	localparam int CntW        = 11;
	localparam int LenW        = 11;
	localparam int ByteW       = 8;
	localparam int HdrW        = ByteW * HeaderBytes;
	localparam int StepW       = $clog2(HeaderBytes + 1);
	localparam int HIdxW       = $clog2(HeaderBytes);

	localparam logic CmdEnq = 1'b0;
	localparam logic CmdDeq = 1'b1;

	typedef enum logic [2:0] {
		StOk      = 3'd0,
		StZero    = 3'd1,
		StNoSpace = 3'd2,
		StNoData  = 3'd3,
		StTooBig  = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_EQ_HDR,
		S_EQ_DATA,
		S_DQ_PEEK,
		S_DQ_CHK,
		S_DQ_RD,
		S_DQ_OUT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic             en;
		logic [PtrW-1:0]  addr;
		logic [ByteW-1:0] data;
	} ram_wr_t;

endpackage

// ===== rtl/length_prefixed_message_ring_unit.sv =====
// Byte ring of 1024 bytes holding variable-length messages, each stored behind a 4-byte
// little-endian length header. Every accepted transaction returns exactly one result
// transaction. One transaction is handled at a time by a small sequencer around a single
// byte RAM port pair and one shared wrapping pointer adder: an accepted enqueue start
// writes the 4 header bytes then the data byte, and an accepted dequeue start reads the
// header through the registered RAM read port before it checks the length and reads the
// data byte. A new transaction is not accepted until the result of the last one has been
// placed in the output register, so a result stalled at the output delays the next accept.
// No clearing pass after reset; the store is only read where it was written.
`include "length_prefixed_message_ring_unit_defines.svh"

module length_prefixed_message_ring_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          cmd,
	input  logic [lpmr_pkg::ByteW-1:0]    data_byte,
	input  logic [lpmr_pkg::LenW-1:0]     length,
	output logic                          out_valid,
	input  logic                          out_stall,
	output lpmr_pkg::status_t             status,
	output logic [lpmr_pkg::ByteW-1:0]    out_byte,
	output logic                          byte_valid,
	output logic                          last_byte,
	output logic                          enqueue_done,
	output logic [lpmr_pkg::CntW-1:0]     message_count,
	output logic [lpmr_pkg::CntW-1:0]     free_bytes
);
	import lpmr_pkg::*;

	state_t state_q, state_d;

	logic [PtrW-1:0]  wp_q, rp_q;
	logic [CntW-1:0]  used_q, msgs_q;
	logic [LenW-1:0]  enq_rem_q, deq_rem_q;
	logic             enq_disc_q;
	logic             out_valid_q;

	logic             cmd_q;
	logic [ByteW-1:0] data_q;
	logic [LenW-1:0]  len_q;
	logic [StepW-1:0] k_q;
	logic [HdrW-1:0]  slen_q;

	status_t          pend_status_q, o_status_q;
	logic [ByteW-1:0] pend_byte_q, o_byte_q;
	logic             pend_valid_q, pend_last_q, pend_done_q;
	logic             o_valid_q, o_last_q, o_done_q;
	logic [CntW-1:0]  o_count_q, o_free_q;

	// shared pointer adder
	logic             use_rp;
	logic [StepW-1:0] ptr_off;
	logic [PtrW-1:0]  ptr_base, ptr_sum;
	logic [PtrW:0]    sum_raw;

	ram_wr_t          wr;
	logic [ByteW-1:0] rdata;

	logic             enq_cont, deq_cont, len_zero, no_space, too_big, slot_free;
	logic [LenW:0]    need;
	logic [CntW-1:0]  free_now;
	logic [HdrW-1:0]  hdr_word;
	logic [ByteW-1:0] hdr_byte;
	logic [StepW-1:0] k_prev;

	assign ptr_base = use_rp ? rp_q : wp_q;
	assign sum_raw  = {1'b0, ptr_base} + (PtrW+1)'(ptr_off);
	assign ptr_sum  = (sum_raw >= (PtrW+1)'(RingBytes)) ?
		PtrW'(sum_raw - (PtrW+1)'(RingBytes)) : sum_raw[PtrW-1:0];

	assign enq_cont  = (enq_rem_q != '0);
	assign deq_cont  = (deq_rem_q != '0);
	assign len_zero  = (len_q == '0);
	assign free_now  = CntW'(RingBytes) - used_q;
	assign need      = {1'b0, len_q} + (LenW+1)'(HeaderBytes);
	assign no_space  = ((LenW+1)'(free_now) < need);
	assign too_big   = (slen_q > HdrW'(len_q));
	assign slot_free = !out_valid_q || !out_stall;
	assign hdr_word  = HdrW'(len_q);
	assign hdr_byte  = hdr_word[ByteW*k_q[HIdxW-1:0] +: ByteW];
	assign k_prev    = k_q - 1'b1;

	lpmr_byte_ram u_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (ptr_sum),
		.rdata (rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd_q == CmdEnq) begin
					if (enq_cont || len_zero || no_space) state_d = S_DONE;
					else state_d = S_EQ_HDR;
				end else begin
					if (deq_cont) state_d = S_DQ_RD;
					else if (msgs_q == '0) state_d = S_DONE;
					else state_d = S_DQ_PEEK;
				end
			end
			S_EQ_HDR: begin
				if (k_q == StepW'(HeaderBytes - 1)) state_d = S_EQ_DATA;
			end
			S_EQ_DATA: state_d = S_DONE;
			S_DQ_PEEK: begin
				if (k_q == StepW'(HeaderBytes)) state_d = S_DQ_CHK;
			end
			S_DQ_CHK: begin
				if (too_big || slen_q == '0) state_d = S_DONE;
				else state_d = S_DQ_RD;
			end
			S_DQ_RD:  state_d = S_DQ_OUT;
			S_DQ_OUT: state_d = S_DONE;
			S_DONE: begin
				if (slot_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		wr.en    = 1'b0;
		wr.addr  = wp_q;
		wr.data  = data_q;
		use_rp   = 1'b0;
		ptr_off  = StepW'(1);
		unique case (state_q)
			S_IDLE: in_stall = 1'b0;
			S_EXEC: begin
				if (cmd_q == CmdEnq && enq_cont && !enq_disc_q) wr.en = 1'b1;
			end
			S_EQ_HDR: begin
				wr.en   = 1'b1;
				wr.data = hdr_byte;
			end
			S_EQ_DATA: wr.en = 1'b1;
			S_DQ_PEEK: begin
				use_rp  = 1'b1;
				ptr_off = k_q;
			end
			S_DQ_CHK: begin
				use_rp  = 1'b1;
				ptr_off = StepW'(HeaderBytes);
			end
			S_DQ_RD: begin
				use_rp  = 1'b1;
				ptr_off = '0;
			end
			S_DQ_OUT: use_rp = 1'b1;
			S_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			rp_q        <= '0;
			used_q      <= '0;
			msgs_q      <= '0;
			enq_rem_q   <= '0;
			enq_disc_q  <= 1'b0;
			deq_rem_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_EXEC: begin
					if (cmd_q == CmdEnq) begin
						if (enq_cont) begin
							enq_rem_q <= enq_rem_q - 1'b1;
							if (!enq_disc_q) begin
								wp_q <= ptr_sum;
								if (enq_rem_q == LenW'(1)) msgs_q <= msgs_q + 1'b1;
							end else if (enq_rem_q == LenW'(1)) begin
								enq_disc_q <= 1'b0;
							end
						end else begin
							enq_disc_q <= 1'b0;
							if (!len_zero) begin
								if (no_space) begin
									enq_rem_q  <= len_q - 1'b1;
									enq_disc_q <= (len_q != LenW'(1));
								end else begin
									used_q <= used_q + CntW'(need);
								end
							end
						end
					end
				end
				S_EQ_HDR: wp_q <= ptr_sum;
				S_EQ_DATA: begin
					wp_q      <= ptr_sum;
					enq_rem_q <= len_q - 1'b1;
					if (len_q == LenW'(1)) msgs_q <= msgs_q + 1'b1;
				end
				S_DQ_CHK: begin
					if (!too_big) begin
						rp_q   <= ptr_sum;
						used_q <= used_q - CntW'(HeaderBytes);
						if (slen_q == '0) msgs_q <= msgs_q - 1'b1;
						else deq_rem_q <= slen_q[LenW-1:0];
					end
				end
				S_DQ_OUT: begin
					rp_q      <= ptr_sum;
					deq_rem_q <= deq_rem_q - 1'b1;
					if (used_q != '0) used_q <= used_q - 1'b1;
					if (deq_rem_q == LenW'(1) && msgs_q != '0) msgs_q <= msgs_q - 1'b1;
				end
				default: ;
			endcase
			if (state_q == S_DONE && slot_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			cmd_q  <= cmd;
			data_q <= data_byte;
			len_q  <= length;
		end
		case (state_q)
			S_EXEC: begin
				pend_status_q <= StOk;
				pend_byte_q   <= '0;
				pend_valid_q  <= 1'b0;
				pend_last_q   <= 1'b0;
				pend_done_q   <= 1'b0;
				k_q           <= '0;
				slen_q        <= '0;
				if (cmd_q == CmdEnq) begin
					if (enq_cont) begin
						if (!enq_disc_q && enq_rem_q == LenW'(1)) pend_done_q <= 1'b1;
					end else if (len_zero) begin
						pend_status_q <= StZero;
					end else if (no_space) begin
						pend_status_q <= StNoSpace;
					end
				end else if (!deq_cont && msgs_q == '0) begin
					pend_status_q <= StNoData;
				end
			end
			S_EQ_HDR: k_q <= k_q + 1'b1;
			S_EQ_DATA: begin
				if (len_q == LenW'(1)) pend_done_q <= 1'b1;
			end
			S_DQ_PEEK: begin
				k_q <= k_q + 1'b1;
				if (k_q != '0) slen_q[ByteW*k_prev[HIdxW-1:0] +: ByteW] <= rdata;
			end
			S_DQ_CHK: begin
				if (too_big) pend_status_q <= StTooBig;
			end
			S_DQ_OUT: begin
				pend_byte_q  <= rdata;
				pend_valid_q <= 1'b1;
				pend_last_q  <= (deq_rem_q == LenW'(1));
			end
			S_DONE: begin
				if (slot_free) begin
					o_status_q <= pend_status_q;
					o_byte_q   <= pend_byte_q;
					o_valid_q  <= pend_valid_q;
					o_last_q   <= pend_last_q;
					o_done_q   <= pend_done_q;
					o_count_q  <= msgs_q;
					o_free_q   <= free_now;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign status        = o_status_q;
	assign out_byte      = o_byte_q;
	assign byte_valid    = o_valid_q;
	assign last_byte     = o_last_q;
	assign enqueue_done  = o_done_q;
	assign message_count = o_count_q;
	assign free_bytes    = o_free_q;

	`LPMR_ASSERT_IMP(a_used_bound, 1'b1, used_q <= CntW'(RingBytes), "fill count above ring size")
	`LPMR_ASSERT_IMP(a_disc_pending, enq_disc_q, enq_rem_q != '0, "discard with nothing left")
	`LPMR_ASSERT_IMP(a_deq_committed, deq_rem_q != '0, msgs_q != '0, "read of uncommitted message")
	`LPMR_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "accept while busy")

endmodule

// ===== rtl/lpmr_byte_ram.sv =====
module lpmr_byte_ram (
	input  logic                         clk,
	input  lpmr_pkg::ram_wr_t            wr,
	input  logic [lpmr_pkg::PtrW-1:0]    raddr,
	output logic [lpmr_pkg::ByteW-1:0]   rdata
);
	import lpmr_pkg::*;

	logic [ByteW-1:0] mem_q [RingBytes];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== tb/sv/length_prefixed_message_ring_unit_tb.sv =====
`timescale 1ns / 1ps

module length_prefixed_message_ring_unit_tb;
	import lpmr_pkg::*;

	localparam int QuietLimit  = 2000;
	localparam int DrainCycles = 40;
	localparam int ItemTarget  = 1750;

	typedef struct {
		logic             cmd;
		logic [ByteW-1:0] data;
		logic [LenW-1:0]  len;
	} ring_op_t;

	typedef struct packed {
		status_t          status;
		logic [ByteW-1:0] data;
		logic             valid;
		logic             last;
		logic             done;
		logic [CntW-1:0]  msgs;
		logic [CntW-1:0]  free;
	} ring_reply_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic             cmd = CmdEnq;
	logic [ByteW-1:0] data_byte = '0;
	logic [LenW-1:0]  length = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	status_t          status;
	logic [ByteW-1:0] out_byte;
	logic             byte_valid;
	logic             last_byte;
	logic             enqueue_done;
	logic [CntW-1:0]  message_count;
	logic [CntW-1:0]  free_bytes;

	ring_op_t    op_q[$];
	ring_reply_t predicted_replies[$];
	bit          fail_seen = 1'b0;

	// predictor state
	logic [ByteW-1:0] ring_mem [RingBytes];
	logic [PtrW-1:0]  wr_ptr;
	logic [PtrW-1:0]  rd_ptr;
	int               used_cnt;
	int               msg_cnt;
	int               enq_left;
	bit               enq_drop;
	int               deq_left;

	// stimulus planning view: message lengths and space only
	int plan_free = RingBytes;
	int plan_enq_left = 0;
	bit plan_enq_drop = 1'b0;
	int plan_cur_len = 0;
	int plan_deq_left = 0;
	int plan_lens[$];

	int       in_hold = 0;
	bit       in_calm = 1'b0;
	ring_op_t next_op;
	int       out_hold = 0;
	bit       out_calm = 1'b0;
	int       out_wait;
	int       quiet_cycles = 0;

	length_prefixed_message_ring_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.data_byte    (data_byte),
		.length       (length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.last_byte    (last_byte),
		.enqueue_done (enqueue_done),
		.message_count(message_count),
		.free_bytes   (free_bytes)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void predict_ring_step(logic op, logic [ByteW-1:0] d, logic [LenW-1:0] len);
		ring_reply_t     r;
		logic [HdrW-1:0] hdr;
		logic [PtrW-1:0] p;
		r = '0;
		r.status = StOk;
		hdr = HdrW'(len);
		if (op == CmdEnq) begin
			if (enq_left > 0) begin
				enq_left--;
				if (!enq_drop) begin
					ring_mem[wr_ptr] = d;
					wr_ptr++;
					if (enq_left == 0) begin
						msg_cnt++;
						r.done = 1'b1;
					end
				end else if (enq_left == 0) begin
					enq_drop = 1'b0;
				end
			end else begin
				enq_drop = 1'b0;
				if (len == 0) begin
					r.status = StZero;
				end else if (RingBytes - used_cnt < int'(len) + HeaderBytes) begin
					r.status = StNoSpace;
					enq_left = int'(len) - 1;
					enq_drop = enq_left > 0;
				end else begin
					used_cnt += int'(len) + HeaderBytes;
					for (int i = 0; i < HeaderBytes; i++) begin
						ring_mem[wr_ptr] = hdr[8*i +: 8];
						wr_ptr++;
					end
					ring_mem[wr_ptr] = d;
					wr_ptr++;
					enq_left = int'(len) - 1;
					if (enq_left == 0) begin
						msg_cnt++;
						r.done = 1'b1;
					end
				end
			end
		end else begin
			if (deq_left == 0) begin
				if (msg_cnt == 0) begin
					r.status = StNoData;
				end else begin
					p = rd_ptr;
					for (int i = 0; i < HeaderBytes; i++) begin
						hdr[8*i +: 8] = ring_mem[p];
						p++;
					end
					if (hdr > HdrW'(len)) begin
						r.status = StTooBig;
					end else begin
						rd_ptr = p;
						used_cnt -= HeaderBytes;
						if (hdr == 0)
							msg_cnt--;
						else
							deq_left = int'(hdr);
					end
				end
			end
			if (deq_left > 0) begin
				r.data = ring_mem[rd_ptr];
				rd_ptr++;
				used_cnt--;
				r.valid = 1'b1;
				deq_left--;
				if (deq_left == 0) begin
					r.last = 1'b1;
					if (msg_cnt > 0)
						msg_cnt--;
				end
			end
		end
		r.msgs = CntW'(msg_cnt);
		r.free = CntW'(RingBytes - used_cnt);
		predicted_replies.push_back(r);
	endfunction

	function automatic void queue_op(logic op, logic [ByteW-1:0] d, logic [LenW-1:0] len);
		op_q.push_back('{op, d, len});
		if (op == CmdEnq) begin
			if (plan_enq_left > 0) begin
				plan_enq_left--;
				if (plan_enq_drop) begin
					if (plan_enq_left == 0)
						plan_enq_drop = 1'b0;
				end else if (plan_enq_left == 0) begin
					plan_lens.push_back(plan_cur_len);
				end
			end else begin
				plan_enq_drop = 1'b0;
				if (len != 0) begin
					plan_enq_left = int'(len) - 1;
					if (plan_free < int'(len) + HeaderBytes) begin
						plan_enq_drop = plan_enq_left > 0;
					end else begin
						plan_free -= int'(len) + HeaderBytes;
						plan_cur_len = int'(len);
						if (plan_enq_left == 0)
							plan_lens.push_back(plan_cur_len);
					end
				end
			end
		end else begin
			if (plan_deq_left == 0 && plan_lens.size() != 0 && plan_lens[0] <= int'(len)) begin
				plan_free += HeaderBytes;
				plan_deq_left = plan_lens[0];
			end
			if (plan_deq_left > 0) begin
				plan_free++;
				plan_deq_left--;
				if (plan_deq_left == 0)
					void'(plan_lens.pop_front());
			end
		end
	endfunction

	function automatic logic [LenW-1:0] pick_msg_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		if (r < 55)
			return LenW'($urandom_range(1, 16));
		if (r < 80)
			return LenW'($urandom_range(17, 128));
		if (r < 92) begin
			if (plan_free > HeaderBytes && plan_free <= 400)
				return LenW'(plan_free - HeaderBytes);
			return LenW'($urandom_range(1, 260));
		end
		if (r < 99) begin
			if (plan_free <= 400)
				return LenW'((plan_free > 3 ? plan_free - 3 : 1) + $urandom_range(0, 8));
			return LenW'($urandom_range(129, 300));
		end
		return LenW'($urandom_range(1024, 2047));
	endfunction

	function automatic logic [LenW-1:0] pick_capacity();
		int hd;
		int r;
		hd = plan_lens.size() != 0 ? plan_lens[0] : $urandom_range(1, 64);
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 20)
			return LenW'(hd - 1);
		if (r < 30)
			return LenW'(hd);
		return LenW'($urandom_range(hd, 2047));
	endfunction

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_seen = 1'b1;
		end
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_hold <= 0;
		end else begin
			if (in_valid && !in_stall)
				predict_ring_step(cmd, data_byte, length);
			if (!in_valid || !in_stall) begin
				if (in_hold != 0) begin
					in_valid <= 1'b0;
					in_hold <= in_hold - 1;
				end else if (op_q.size() != 0) begin
					next_op = op_q.pop_front();
					in_valid <= 1'b1;
					cmd <= next_op.cmd;
					data_byte <= next_op.data;
					length <= next_op.len;
					in_hold <= in_calm ? 0 : $urandom_range(0, 15);
				end else begin
					in_valid <= 1'b0;
				end
			end
			if ($urandom_range(0, 299) == 0)
				in_calm <= !in_calm;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (predicted_replies.size() == 0) begin
					$error("result transaction with no prediction pending");
					fail_seen = 1'b1;
				end else begin
					ring_reply_t want;
					want = predicted_replies.pop_front();
					check_field("status", 16'(want.status), 16'(status));
					check_field("out_byte", 16'(want.data), 16'(out_byte));
					check_field("byte_valid", 16'(want.valid), 16'(byte_valid));
					check_field("last_byte", 16'(want.last), 16'(last_byte));
					check_field("enqueue_done", 16'(want.done), 16'(enqueue_done));
					check_field("message_count", 16'(want.msgs), 16'(message_count));
					check_field("free_bytes", 16'(want.free), 16'(free_bytes));
				end
				out_wait = out_calm ? 0 : $urandom_range(0, 15);
				out_hold <= out_wait;
				out_stall <= (out_wait != 0);
			end else if (out_valid && out_hold != 0) begin
				out_hold <= out_hold - 1;
				out_stall <= (out_hold != 1);
			end
			if ($urandom_range(0, 299) == 0)
				out_calm <= !out_calm;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		bit fill_phase;
		wr_ptr = '0;
		rd_ptr = '0;
		used_cnt = 0;
		msg_cnt = 0;
		enq_left = 0;
		enq_drop = 1'b0;
		deq_left = 0;

		// directed: empty ring, zero length, capacity edges, interleave
		queue_op(CmdDeq, 8'h00, 11'd0);
		queue_op(CmdDeq, 8'hFF, 11'd2047);
		queue_op(CmdEnq, 8'h00, 11'd0);
		queue_op(CmdEnq, 8'hFF, 11'd1);
		queue_op(CmdDeq, 8'h00, 11'd0);
		queue_op(CmdDeq, 8'h00, 11'd1);
		queue_op(CmdEnq, 8'h00, 11'd3);
		queue_op(CmdDeq, 8'h00, 11'd2047);
		queue_op(CmdEnq, 8'hA5, 11'd2047);
		queue_op(CmdEnq, 8'h5A, 11'd0);
		queue_op(CmdDeq, 8'h00, 11'd2);
		queue_op(CmdDeq, 8'h00, 11'd3);
		queue_op(CmdEnq, 8'h81, 11'd2);
		queue_op(CmdDeq, 8'hFF, 11'd0);
		queue_op(CmdEnq, 8'h7E, 11'd1024);
		queue_op(CmdDeq, 8'h00, 11'd1024);
		queue_op(CmdDeq, 8'h00, 11'd2);
		queue_op(CmdDeq, 8'h00, 11'd0);
		queue_op(CmdDeq, 8'h00, 11'd5);
		queue_op(CmdEnq, 8'hC3, 11'd1);
		queue_op(CmdDeq, 8'h00, 11'd1024);

		fill_phase = 1'b1;
		while (op_q.size() < ItemTarget) begin
			if ($urandom_range(0, 399) == 0)
				fill_phase = !fill_phase;
			if ($urandom_range(0, 99) < 3) begin
				queue_op(1'($urandom_range(0, 1)), 8'($urandom),
					plan_enq_left > 0 ? 11'($urandom_range(0, 2047)) : pick_msg_len());
			end else if ($urandom_range(0, 99) < (fill_phase ? 90 : 20)) begin
				if (plan_enq_left > 0)
					queue_op(CmdEnq, 8'($urandom), 11'($urandom_range(0, 2047)));
				else
					queue_op(CmdEnq, 8'($urandom), pick_msg_len());
			end else begin
				if (plan_deq_left > 0)
					queue_op(CmdDeq, 8'($urandom), 11'($urandom_range(0, 2047)));
				else
					queue_op(CmdDeq, 8'($urandom), pick_capacity());
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (op_q.size() != 0 || in_valid || predicted_replies.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (!fail_seen)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lpmr_pkg.sv
rtl/lpmr_byte_ram.sv
rtl/length_prefixed_message_ring_unit.sv
tb/sv/length_prefixed_message_ring_unit_tb.sv
